>>> design/rdoc_pkg.sv
// Shared types and constants for the RPL DIS option checker.
package rdoc_pkg;

    // Option type codes
    localparam logic [7:0] OPT_PAD1    = 8'd0;
    localparam logic [7:0] OPT_PADN    = 8'd1;
    localparam logic [7:0] OPT_SOLINFO = 8'd7;

    // Solicited Information option body length
    localparam logic [7:0] SOLINFO_LEN = 8'd19;

    // Predicate flag bit positions in the V/I/D byte
    localparam int FLAG_V_BIT = 7;
    localparam int FLAG_I_BIT = 6;
    localparam int FLAG_D_BIT = 5;

    // Bits of the options-seen mask
    localparam int SEEN_PAD1_BIT    = 0;
    localparam int SEEN_PADN_BIT    = 1;
    localparam int SEEN_SOLINFO_BIT = 7;

    // Offsets inside a Solicited Information option
    localparam logic [8:0] OFF_TYPE     = 9'd0;
    localparam logic [8:0] OFF_LENGTH   = 9'd1;
    localparam logic [8:0] OFF_INSTANCE = 9'd2;
    localparam logic [8:0] OFF_FLAGS    = 9'd3;
    localparam logic [8:0] OFF_ID_FIRST = 9'd4;
    localparam logic [8:0] OFF_ID_LAST  = 9'd19;

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_INSTANCE_ACTIVE = 3'd0,
        CFG_NODE_IS_LEAF    = 3'd1,
        CFG_INSTANCE_NUMBER = 3'd2,
        CFG_DODAG_VERSION   = 3'd3,
        CFG_DODAG_ID_UPPER  = 3'd4,
        CFG_DODAG_ID_LOWER  = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic        instance_active;
        logic        node_is_leaf;
        logic [7:0]  instance_number;
        logic [7:0]  dodag_version;
        logic [63:0] dodag_id_upper;
        logic [63:0] dodag_id_lower;
    } t_cfg;

    typedef struct packed {
        logic       verdict;
        logic       send_dio;
        logic       reset_trickle;
        logic [7:0] options_seen;
        logic       conf_requested;
    } t_result;

endpackage

>>> design/rdoc_cfg_regs.sv
// Configuration register file of the RPL DIS option checker.
module rdoc_cfg_regs
    import rdoc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    input  logic [2:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data,
    output t_cfg        o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    // Decode a write; unknown indexes leave everything as is
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_INSTANCE_ACTIVE: n_cfg.instance_active = i_cfg_data[0];
                CFG_NODE_IS_LEAF:    n_cfg.node_is_leaf    = i_cfg_data[0];
                CFG_INSTANCE_NUMBER: n_cfg.instance_number = i_cfg_data[7:0];
                CFG_DODAG_VERSION:   n_cfg.dodag_version   = i_cfg_data[7:0];
                CFG_DODAG_ID_UPPER:  n_cfg.dodag_id_upper  = i_cfg_data;
                CFG_DODAG_ID_LOWER:  n_cfg.dodag_id_lower  = i_cfg_data;
                default:             n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

>>> design/rdoc_parser.sv
// Option walker: per-byte TLV parsing state and the end-of-message verdict.
module rdoc_parser
    import rdoc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  logic [7:0] i_option_byte,
    input  logic       i_byte_present,
    input  logic       i_last_byte,
    input  logic       i_dest_multicast,
    input  t_cfg       i_cfg,
    output t_result    o_result
);

    logic [8:0] r_offset, n_offset;
    logic [7:0] r_type, n_type;
    logic [7:0] r_length, n_length;
    logic [7:0] r_flags, n_flags;
    logic       r_mismatch, n_mismatch;
    logic       r_error, n_error;
    logic [7:0] r_seen, n_seen;
    logic       r_conf, n_conf;

    logic [127:0] root_id;
    logic [3:0]   id_idx;
    logic [7:0]   id_byte;
    logic         body_error;
    t_result      result;

    // DODAG id byte for the current offset (bytes 4..19 of the option)
    assign root_id = {i_cfg.dodag_id_upper, i_cfg.dodag_id_lower};
    assign id_idx  = r_offset[3:0] - OFF_ID_FIRST[3:0];
    assign id_byte = root_id[(7'd127 - {id_idx, 3'b000}) -: 8];

    always_comb begin
        n_offset   = r_offset;
        n_type     = r_type;
        n_length   = r_length;
        n_flags    = r_flags;
        n_mismatch = r_mismatch;
        n_error    = r_error;
        n_seen     = r_seen;
        n_conf     = r_conf;
        body_error = 1'b0;
        result     = '0;

        if (i_step) begin
            // Byte walk; nothing moves once an error is latched
            if (i_byte_present && !r_error) begin
                if (r_offset == OFF_TYPE) begin
                    if (i_option_byte == OPT_PAD1) begin
                        n_seen[SEEN_PAD1_BIT] = 1'b1;
                    end else begin
                        if (i_option_byte == OPT_PADN) begin
                            n_seen[SEEN_PADN_BIT] = 1'b1;
                        end else if (i_option_byte == OPT_SOLINFO) begin
                            n_seen[SEEN_SOLINFO_BIT] = 1'b1;
                        end
                        n_type   = i_option_byte;
                        n_offset = OFF_LENGTH;
                    end
                end else if (r_offset == OFF_LENGTH) begin
                    n_length = i_option_byte;
                    if (r_type == OPT_SOLINFO && i_option_byte != SOLINFO_LEN) begin
                        n_error = 1'b1;
                    end else begin
                        n_offset = (i_option_byte == 8'd0) ? OFF_TYPE : OFF_INSTANCE;
                    end
                end else begin
                    // SolInfo body checks
                    if (r_type == OPT_SOLINFO) begin
                        if (r_offset == OFF_INSTANCE) begin
                            n_mismatch = (i_option_byte != i_cfg.instance_number);
                        end else if (r_offset == OFF_FLAGS) begin
                            n_flags    = i_option_byte;
                            body_error = i_option_byte[FLAG_I_BIT] && r_mismatch;
                        end else if (r_offset <= OFF_ID_LAST) begin
                            body_error = r_flags[FLAG_D_BIT] && (i_option_byte != id_byte);
                        end else begin
                            body_error = r_flags[FLAG_V_BIT]
                                         && (i_option_byte != i_cfg.dodag_version);
                        end
                    end
                    if (body_error) begin
                        n_error = 1'b1;
                    end else if (r_offset == ({1'b0, r_length} + 9'd1)) begin
                        n_offset = OFF_TYPE;
                    end else begin
                        n_offset = r_offset + 9'd1;
                    end
                end
            end

            // End of message: judge, then clear per-message state
            if (i_last_byte) begin
                if (n_offset != OFF_TYPE) begin
                    n_error = 1'b1;
                end
                if (i_dest_multicast) begin
                    result.reset_trickle = i_cfg.instance_active && !i_cfg.node_is_leaf;
                end else if (i_cfg.instance_active) begin
                    if (n_error) begin
                        result.verdict = 1'b1;
                    end else begin
                        n_conf              = 1'b1;
                        result.send_dio     = 1'b1;
                        result.options_seen = n_seen;
                    end
                end
                result.conf_requested = n_conf;
                n_offset   = OFF_TYPE;
                n_type     = '0;
                n_length   = '0;
                n_flags    = '0;
                n_mismatch = 1'b0;
                n_error    = 1'b0;
                n_seen     = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset   <= '0;
            r_type     <= '0;
            r_length   <= '0;
            r_flags    <= '0;
            r_mismatch <= 1'b0;
            r_error    <= 1'b0;
            r_seen     <= '0;
            r_conf     <= 1'b0;
        end else begin
            r_offset   <= n_offset;
            r_type     <= n_type;
            r_length   <= n_length;
            r_flags    <= n_flags;
            r_mismatch <= n_mismatch;
            r_error    <= n_error;
            r_seen     <= n_seen;
            r_conf     <= n_conf;
        end
    end

    assign o_result = result;

    // Sticky config request never drops outside reset
    a_conf_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_conf |=> r_conf)
        else $error("config request flag cleared");

    // Every message end leaves the walker at a type byte
    a_offset_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && i_last_byte) |=> (r_offset == OFF_TYPE && !r_error))
        else $error("walker state not cleared at message end");

    // A latched error only goes away at a message end
    a_error_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_error && !(i_step && i_last_byte)) |=> r_error)
        else $error("error flag dropped inside a message");

    // An error verdict never comes with a DIO request
    a_verdict_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        result.verdict |-> (!result.send_dio && result.options_seen == 8'd0))
        else $error("error verdict with DIO request");

endmodule

>>> design/rpl_dis_option_checker_top.sv
// A message's result is loaded into the result register when its last word leaves the input register.
// Throughput: one option byte per cycle.
// A last word waits in the input register only while the result register is full
// and not being read.
// Reset (synchronous, active low) clears configuration, walker state,
// the sticky DODAG-configuration request and both valid flags.
module rpl_dis_option_checker_top
    import rdoc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input channel
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_option_byte,
    input  logic        i_byte_present,
    input  logic        i_last_byte,
    input  logic        i_dest_multicast,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_verdict,
    output logic        o_send_dio,
    output logic        o_reset_trickle,
    output logic [7:0]  o_options_seen,
    output logic        o_conf_requested,
    // configuration channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data
);

    logic       r_in_valid;
    logic [7:0] r_byte;
    logic       r_present;
    logic       r_last;
    logic       r_mcast;
    logic       r_out_valid;
    t_result    r_out;

    t_cfg       cfg;
    t_result    result;
    logic       out_free;
    logic       in_go;

    assign o_cfg_ready = 1'b1;

    rdoc_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // Held word moves on unless it is a last word blocked by a full result slot
    assign out_free   = !r_out_valid || i_out_ready;
    assign in_go      = r_in_valid && (!r_last || out_free);
    assign o_in_ready = !r_in_valid || in_go;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_byte    <= i_option_byte;
            r_present <= i_byte_present;
            r_last    <= i_last_byte;
            r_mcast   <= i_dest_multicast;
        end
    end

    rdoc_parser u_parser (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_step           (in_go),
        .i_option_byte    (r_byte),
        .i_byte_present   (r_present),
        .i_last_byte      (r_last),
        .i_dest_multicast (r_mcast),
        .i_cfg            (cfg),
        .o_result         (result)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_go && r_last) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_go && r_last) begin
            r_out <= result;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_verdict        = r_out.verdict;
    assign o_send_dio       = r_out.send_dio;
    assign o_reset_trickle  = r_out.reset_trickle;
    assign o_options_seen   = r_out.options_seen;
    assign o_conf_requested = r_out.conf_requested;

    // A DIO request always reports the sticky flag set
    a_dio_conf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_send_dio) |-> o_conf_requested)
        else $error("DIO request without config request flag");

    // Trickle reset and DIO request never come together
    a_trickle_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_reset_trickle) |-> (!o_send_dio && !o_verdict))
        else $error("trickle reset mixed with unicast result");

    // A non-last word never fills the result slot
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_go && !r_last && !(r_out_valid && !i_out_ready)) |=> !o_out_valid)
        else $error("result produced for a non-last word");

endmodule

>>> test/tb_rpl_dis_option_checker_top.sv
// Testbench for the RPL DIS option checker: option-byte streams checked against a walker model.
module tb_rpl_dis_option_checker_top;
    timeunit 1ns;
    timeprecision 1ps;
    import rdoc_pkg::*;

    localparam int LATENCY      = 2;
    localparam int RANDOM_ITEMS = 1200;
    localparam int IDLE_PCT     = 28;
    localparam int RUN_LIMIT_NS = 5_000_000;

    // indexes past the register list, writes there must be dropped
    localparam logic [2:0] CFG_SPARE_LO = 3'(CFG_DODAG_ID_LOWER) + 3'd1;
    localparam logic [2:0] CFG_SPARE_HI = 3'd7;

    localparam logic [7:0] FLAGS_VID = (8'd1 << FLAG_V_BIT) | (8'd1 << FLAG_I_BIT) |
                                       (8'd1 << FLAG_D_BIT);
    localparam logic [7:0] FLAGS_NONE = 8'h00;

    typedef enum {OPT_KIND_PAD1, OPT_KIND_PADN, OPT_KIND_OTHER, OPT_KIND_SOLINFO} t_opt_kind;
    typedef enum {FLAW_NONE, FLAW_LENGTH, FLAW_INSTANCE, FLAW_ID, FLAW_VERSION} t_flaw;

    logic        clk          = 1'b0;
    logic        rst_n        = 1'b0;
    logic        in_valid     = 1'b0;
    logic [7:0]  opt_byte     = 8'h00;
    logic        byte_present = 1'b0;
    logic        last_byte    = 1'b0;
    logic        dest_mcast   = 1'b0;
    logic        out_ready    = 1'b0;
    logic        cfg_valid    = 1'b0;
    logic [2:0]  cfg_index    = 3'd0;
    logic [63:0] cfg_data     = 64'd0;

    logic        o_in_ready;
    logic        o_out_valid;
    logic        o_verdict;
    logic        o_send_dio;
    logic        o_reset_trickle;
    logic [7:0]  o_options_seen;
    logic        o_conf_requested;
    logic        o_cfg_ready;

    // walker model state and its copy of the registers
    t_cfg        model_cfg     = '0;
    logic [8:0]  walk_off      = '0;
    logic [7:0]  walk_type     = '0;
    logic [7:0]  walk_len      = '0;
    logic [7:0]  walk_flags    = '0;
    logic [7:0]  walk_seen     = '0;
    logic        walk_mismatch = 1'b0;
    logic        walk_err      = 1'b0;
    logic        conf_sticky   = 1'b0;

    t_result     expected_q[$];
    int          error_count = 0;
    int          items_sent  = 0;
    bit          no_stall    = 1'b0;

    rpl_dis_option_checker_top dut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .o_in_ready       (o_in_ready),
        .i_option_byte    (opt_byte),
        .i_byte_present   (byte_present),
        .i_last_byte      (last_byte),
        .i_dest_multicast (dest_mcast),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (out_ready),
        .o_verdict        (o_verdict),
        .o_send_dio       (o_send_dio),
        .o_reset_trickle  (o_reset_trickle),
        .o_options_seen   (o_options_seen),
        .o_conf_requested (o_conf_requested),
        .i_cfg_valid      (cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (cfg_index),
        .i_cfg_data       (cfg_data)
    );

    // 10 ns clock
    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // receiver stalls at random unless a steady stretch is running
    always @(posedge clk) begin
        out_ready <= no_stall || ($urandom_range(99) >= IDLE_PCT);
    end

    task automatic report_error(input string what, input logic [7:0] got, input logic [7:0] want);
        $display("ERROR %0t ns: %s got %h want %h", $time, what, got, want);
        error_count++;
    endtask

    // Walk one word through the option parser; returns 1 when the word ends a message.
    function automatic bit walk_dis_word(input logic [7:0] b, input logic present,
                                         input logic last, input logic mcast,
                                         output t_result res);
        logic [127:0] id;
        int           k;
        res = '0;
        id  = {model_cfg.dodag_id_upper, model_cfg.dodag_id_lower};
        if (present && !walk_err) begin
            if (walk_off == OFF_TYPE) begin
                if (b == OPT_PAD1) begin
                    walk_seen[SEEN_PAD1_BIT] = 1'b1;
                end else begin
                    if (b == OPT_PADN)
                        walk_seen[SEEN_PADN_BIT] = 1'b1;
                    else if (b == OPT_SOLINFO)
                        walk_seen[SEEN_SOLINFO_BIT] = 1'b1;
                    walk_type = b;
                    walk_off  = OFF_LENGTH;
                end
            end else if (walk_off == OFF_LENGTH) begin
                walk_len = b;
                if (walk_type == OPT_SOLINFO && b != SOLINFO_LEN)
                    walk_err = 1'b1;
                else
                    walk_off = (b == 8'd0) ? OFF_TYPE : OFF_INSTANCE;
            end else begin
                // SolInfo body: instance, flags, DODAG id, version
                if (walk_type == OPT_SOLINFO) begin
                    if (walk_off == OFF_INSTANCE) begin
                        walk_mismatch = (b != model_cfg.instance_number);
                    end else if (walk_off == OFF_FLAGS) begin
                        walk_flags = b;
                        if (b[FLAG_I_BIT] && walk_mismatch)
                            walk_err = 1'b1;
                    end else if (walk_off <= OFF_ID_LAST) begin
                        k = int'(walk_off - OFF_ID_FIRST);
                        if (walk_flags[FLAG_D_BIT] && b != id[127 - 8*k -: 8])
                            walk_err = 1'b1;
                    end else if (walk_flags[FLAG_V_BIT] && b != model_cfg.dodag_version) begin
                        walk_err = 1'b1;
                    end
                end
                if (!walk_err)
                    walk_off = (walk_off == 9'(walk_len) + 9'd1) ? OFF_TYPE : walk_off + 9'd1;
            end
        end
        if (!last)
            return 1'b0;

        // message end: truncated option is an error
        if (walk_off != OFF_TYPE)
            walk_err = 1'b1;
        if (mcast) begin
            res.reset_trickle = model_cfg.instance_active && !model_cfg.node_is_leaf;
        end else if (model_cfg.instance_active) begin
            if (walk_err) begin
                res.verdict = 1'b1;
            end else begin
                conf_sticky      = 1'b1;
                res.send_dio     = 1'b1;
                res.options_seen = walk_seen;
            end
        end
        res.conf_requested = conf_sticky;
        walk_off      = '0;
        walk_type     = '0;
        walk_len      = '0;
        walk_flags    = '0;
        walk_seen     = '0;
        walk_mismatch = 1'b0;
        walk_err      = 1'b0;
        return 1'b1;
    endfunction

    // result checker: every accepted word against the oldest expectation
    always @(posedge clk) begin : check_results
        t_result want;
        if (o_out_valid === 1'b1 && out_ready) begin
            if (expected_q.size() == 0) begin
                report_error("result with nothing expected", o_options_seen, 8'h00);
            end else begin
                want = expected_q.pop_front();
                if (o_verdict !== want.verdict)
                    report_error("verdict", 8'(o_verdict), 8'(want.verdict));
                if (o_send_dio !== want.send_dio)
                    report_error("send_dio", 8'(o_send_dio), 8'(want.send_dio));
                if (o_reset_trickle !== want.reset_trickle)
                    report_error("reset_trickle", 8'(o_reset_trickle), 8'(want.reset_trickle));
                if (o_options_seen !== want.options_seen)
                    report_error("options_seen", o_options_seen, want.options_seen);
                if (o_conf_requested !== want.conf_requested)
                    report_error("conf_requested", 8'(o_conf_requested), 8'(want.conf_requested));
            end
        end
    end

    // send one word, with a random idle gap in front
    task automatic send_word(input logic [7:0] b, input logic present, input logic last,
                             input logic mcast);
        int      gap;
        t_result res;
        gap = 0;
        while (!no_stall && $urandom_range(99) < IDLE_PCT)
            gap++;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        opt_byte     <= b;
        byte_present <= present;
        last_byte    <= last;
        dest_mcast   <= mcast;
        do @(posedge clk); while (!o_in_ready);
        if (walk_dis_word(b, present, last, mcast, res))
            expected_q.push_back(res);
        if (present || last)
            items_sent++;
    endtask

    // send a whole option area; empty words are slipped in now and then
    task automatic send_message(input logic [7:0] q[$], input logic mcast, input bit tail_empty);
        for (int i = 0; i < q.size(); i++) begin
            if ($urandom_range(99) < 5)
                send_word(8'($urandom_range(255)), 1'b0, 1'b0, mcast);
            send_word(q[i], 1'b1, (i == q.size() - 1) && !tail_empty, mcast);
        end
        if (tail_empty || q.size() == 0)
            send_word(8'($urandom_range(255)), 1'b0, 1'b1, mcast);
    endtask

    // stop sending until all results are back, optionally letting the pipe empty
    task automatic drain_results(input bit tail);
        in_valid <= 1'b0;
        do @(posedge clk); while (expected_q.size() != 0);
        if (tail)
            repeat (LATENCY + 2) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [2:0] idx, input logic [63:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!o_cfg_ready);
        case (idx)
            CFG_INSTANCE_ACTIVE: model_cfg.instance_active = data[0];
            CFG_NODE_IS_LEAF:    model_cfg.node_is_leaf    = data[0];
            CFG_INSTANCE_NUMBER: model_cfg.instance_number = data[7:0];
            CFG_DODAG_VERSION:   model_cfg.dodag_version   = data[7:0];
            CFG_DODAG_ID_UPPER:  model_cfg.dodag_id_upper  = data;
            CFG_DODAG_ID_LOWER:  model_cfg.dodag_id_lower  = data;
            default: ;
        endcase
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // write every register; unused upper data bits carry junk
    task automatic apply_config(input t_cfg c);
        logic [63:0] junk;
        drain_results(1'b1);
        junk = {$urandom, $urandom};
        cfg_write(CFG_INSTANCE_ACTIVE, {junk[63:1], c.instance_active});
        cfg_write(CFG_NODE_IS_LEAF,    {junk[63:1], c.node_is_leaf});
        cfg_write(CFG_INSTANCE_NUMBER, {junk[63:8], c.instance_number});
        cfg_write(CFG_DODAG_VERSION,   {junk[63:8], c.dodag_version});
        cfg_write(CFG_DODAG_ID_UPPER,  c.dodag_id_upper);
        cfg_write(CFG_DODAG_ID_LOWER,  c.dodag_id_lower);
    endtask

    // append one option; arg is the length, or the flags byte of a SolInfo
    task automatic add_option(ref logic [7:0] q[$], input t_opt_kind kind,
                              input logic [7:0] arg, input t_flaw flaw);
        logic [7:0]   body[$];
        logic [127:0] id;
        logic [7:0]   code;
        int           pos;
        id = {model_cfg.dodag_id_upper, model_cfg.dodag_id_lower};
        case (kind)
            OPT_KIND_PAD1: begin
                q.push_back(OPT_PAD1);
            end
            OPT_KIND_PADN, OPT_KIND_OTHER: begin
                code = OPT_PADN;
                if (kind == OPT_KIND_OTHER) begin
                    do code = 8'($urandom_range(255));
                    while (code == OPT_PAD1 || code == OPT_PADN || code == OPT_SOLINFO);
                end
                q.push_back(code);
                q.push_back(arg);
                repeat (arg) q.push_back(8'($urandom_range(255)));
            end
            OPT_KIND_SOLINFO: begin
                body.push_back(model_cfg.instance_number);
                body.push_back(arg);
                for (int i = 0; i < 16; i++)
                    body.push_back(id[127 - 8*i -: 8]);
                body.push_back(model_cfg.dodag_version);
                case (flaw)
                    FLAW_INSTANCE: pos = 0;
                    FLAW_ID:       pos = $urandom_range(2, 17);
                    FLAW_VERSION:  pos = 18;
                    default:       pos = -1;
                endcase
                if (pos >= 0)
                    body[pos] = body[pos] ^ 8'($urandom_range(1, 255));
                code = SOLINFO_LEN;
                if (flaw == FLAW_LENGTH) begin
                    do code = 8'($urandom_range(255)); while (code == SOLINFO_LEN);
                end
                q.push_back(OPT_SOLINFO);
                q.push_back(code);
                foreach (body[i]) q.push_back(body[i]);
            end
            default: ;
        endcase
    endtask

    // out of reset the instance is off: nothing is judged
    task automatic test_inactive_defaults();
        logic [7:0] msg[$];
        add_option(msg, OPT_KIND_PAD1, 8'd0, FLAW_NONE);
        send_message(msg, 1'b0, 1'b0);
        msg.delete();
        msg.push_back(OPT_SOLINFO);
        send_message(msg, 1'b0, 1'b0);
        send_message(msg, 1'b1, 1'b1);
    endtask

    // Pad1, PadN, unknown types, longest PadN
    task automatic test_padding_and_unknown();
        t_cfg       c;
        logic [7:0] msg[$];
        c = '0;
        c.instance_active = 1'b1;
        c.instance_number = 8'hFF;
        c.dodag_version   = 8'h00;
        c.dodag_id_upper  = '1;
        c.dodag_id_lower  = '0;
        apply_config(c);
        add_option(msg, OPT_KIND_PAD1, 8'd0, FLAW_NONE);
        add_option(msg, OPT_KIND_PADN, 8'd0, FLAW_NONE);
        add_option(msg, OPT_KIND_PADN, 8'd2, FLAW_NONE);
        add_option(msg, OPT_KIND_OTHER, 8'd1, FLAW_NONE);
        msg.push_back(8'hFF);
        msg.push_back(8'h00);
        send_message(msg, 1'b0, 1'b0);
        msg.delete();
        add_option(msg, OPT_KIND_PADN, 8'hFF, FLAW_NONE);
        send_message(msg, 1'b0, 1'b1);
    endtask

    // SolInfo match, wrong length, and each field mismatch with and without its flag
    task automatic test_solicited_info();
        logic [7:0] msg[$];
        add_option(msg, OPT_KIND_PAD1, 8'd0, FLAW_NONE);
        add_option(msg, OPT_KIND_SOLINFO, FLAGS_VID, FLAW_NONE);
        send_message(msg, 1'b0, 1'b0);
        msg.delete();
        add_option(msg, OPT_KIND_SOLINFO, 8'hFF, FLAW_NONE);
        send_message(msg, 1'b0, 1'b0);
        // bytes after an error are ignored
        msg.delete();
        add_option(msg, OPT_KIND_SOLINFO, FLAGS_VID, FLAW_LENGTH);
        add_option(msg, OPT_KIND_PAD1, 8'd0, FLAW_NONE);
        send_message(msg, 1'b0, 1'b0);
        for (int f = FLAW_INSTANCE; f <= FLAW_VERSION; f++) begin
            msg.delete();
            add_option(msg, OPT_KIND_SOLINFO, FLAGS_VID, t_flaw'(f));
            send_message(msg, 1'b0, 1'b0);
            msg.delete();
            add_option(msg, OPT_KIND_SOLINFO, FLAGS_NONE, t_flaw'(f));
            send_message(msg, 1'b0, 1'b0);
        end
    endtask

    // truncated options, empty words, empty message
    task automatic test_truncation_and_gaps();
        logic [7:0] msg[$];
        add_option(msg, OPT_KIND_PADN, 8'd4, FLAW_NONE);
        void'(msg.pop_back());
        void'(msg.pop_back());
        send_message(msg, 1'b0, 1'b0);
        msg.delete();
        msg.push_back(OPT_PADN);
        send_message(msg, 1'b0, 1'b1);
        send_word(8'hFF, 1'b0, 1'b0, 1'b0);
        send_word(OPT_PAD1, 1'b1, 1'b0, 1'b0);
        send_word(8'h00, 1'b0, 1'b0, 1'b0);
        send_word(8'hA5, 1'b0, 1'b1, 1'b0);
        msg.delete();
        send_message(msg, 1'b0, 1'b0);
    endtask

    // multicast: trickle reset only on an active non-leaf node
    task automatic test_multicast();
        logic [7:0] msg[$];
        add_option(msg, OPT_KIND_PADN, 8'd1, FLAW_NONE);
        send_message(msg, 1'b1, 1'b0);
        msg.push_back(OPT_SOLINFO);
        send_message(msg, 1'b1, 1'b0);
        drain_results(1'b1);
        cfg_write(CFG_NODE_IS_LEAF, 64'd1);
        send_message(msg, 1'b1, 1'b1);
        send_message(msg, 1'b0, 1'b0);
    endtask

    // writes past the last register change nothing
    task automatic test_spare_registers();
        logic [7:0] msg[$];
        drain_results(1'b1);
        cfg_write(CFG_SPARE_LO, '1);
        cfg_write(CFG_SPARE_HI, {$urandom, $urandom});
        add_option(msg, OPT_KIND_SOLINFO, FLAGS_VID, FLAW_NONE);
        send_message(msg, 1'b0, 1'b0);
    endtask

    // random messages over several register settings
    task automatic test_random_traffic();
        t_cfg       c;
        logic [7:0] msg[$];
        int         goal;
        int         pick;
        logic [7:0] len;
        t_flaw      flaw;
        for (int phase = 0; phase < 8; phase++) begin
            c.instance_active = 1'b1;
            c.node_is_leaf    = ($urandom_range(3) == 0);
            c.instance_number = 8'($urandom);
            c.dodag_version   = 8'($urandom);
            c.dodag_id_upper  = {$urandom, $urandom};
            c.dodag_id_lower  = {$urandom, $urandom};
            if (phase == 0) begin
                c = '0;
                c.instance_active = 1'b1;
            end else if (phase == 1) begin
                c = '1;
            end else if (phase == 2) begin
                c.instance_active = 1'b0;
            end
            apply_config(c);
            no_stall = (phase == 4);
            goal = items_sent + RANDOM_ITEMS / 8;
            while (items_sent < goal) begin
                msg.delete();
                pick = $urandom_range(99);
                if (pick < 88) begin
                    repeat ($urandom_range(0, 4)) begin
                        len  = ($urandom_range(99) < 3) ? 8'($urandom_range(255))
                                                        : 8'($urandom_range(0, 6));
                        flaw = ($urandom_range(99) < 25) ? t_flaw'($urandom_range(1, 4))
                                                         : FLAW_NONE;
                        case ($urandom_range(3))
                            0: add_option(msg, OPT_KIND_PAD1, 8'd0, FLAW_NONE);
                            1: add_option(msg, OPT_KIND_PADN, len, FLAW_NONE);
                            2: add_option(msg, OPT_KIND_OTHER, len, FLAW_NONE);
                            default: add_option(msg, OPT_KIND_SOLINFO,
                                                8'($urandom_range(255)), flaw);
                        endcase
                    end
                    // cut some well-formed areas short
                    if (pick >= 75 && msg.size() > 0)
                        repeat ($urandom_range(1, msg.size())) void'(msg.pop_back());
                end else begin
                    repeat ($urandom_range(1, 30)) msg.push_back(8'($urandom_range(255)));
                end
                send_message(msg, $urandom_range(99) < 15, $urandom_range(99) < 15);
                if ($urandom_range(99) < 4)
                    drain_results(1'b0);
            end
        end
        no_stall = 1'b0;
    endtask

    initial begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        test_inactive_defaults();
        test_padding_and_unknown();
        test_solicited_info();
        test_truncation_and_gaps();
        test_multicast();
        test_spare_registers();
        test_random_traffic();
        drain_results(1'b1);
        if (error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // run limit
    initial begin
        #RUN_LIMIT_NS;
        $display("Verification failed");
        $finish;
    end

endmodule

>>> rpl_dis_option_checker_top.f
design/rdoc_pkg.sv
design/rdoc_cfg_regs.sv
design/rdoc_parser.sv
design/rpl_dis_option_checker_top.sv
test/tb_rpl_dis_option_checker_top.sv
